// File: rtl/tcpq_pkg.sv
// tcpq_pkg: shared types and constants for the two-class priority queue
// used by tcpq_cell and two_class_priority_queue; depends on nothing else

package tcpq_pkg;

  localparam int OP_W  = 2;
  localparam int ID_W  = 31;
  localparam int OCC_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_SERVE    = 2'd1,
    OP_WITHDRAW = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_t;

  // per-cycle move command broadcast to every cell, already qualified
  typedef struct packed {
    logic ins_pref;   // preferred insert behind the last preferred entry
    logic ins_tail;   // ordinary insert at the tail
    logic serve;      // remove head, whole row moves toward the head
    logic withdraw;   // remove at hit position, tail side moves up
  } cmd_t;

endpackage

// File: rtl/tcpq_cell.sv
// tcpq_cell: one slot of the queue row, holds an id and its class
// compares against the request id and takes data from a neighbor or the input
// depends on tcpq_pkg

module tcpq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int IW  = 4
) (
  input  logic                    clk,
  input  tcpq_pkg::cmd_t          cmd,
  input  logic [tcpq_pkg::ID_W-1:0] req_id,
  input  logic                    req_cls,
  input  logic [CW-1:0]           count,
  input  logic [CW-1:0]           pcount,
  input  logic [IW-1:0]           hit_pos,
  input  logic [tcpq_pkg::ID_W-1:0] left_id,
  input  logic                    left_cls,
  input  logic [tcpq_pkg::ID_W-1:0] right_id,
  input  logic                    right_cls,
  output logic [tcpq_pkg::ID_W-1:0] id,
  output logic                    cls,
  output logic                    match
);

  localparam logic [CW-1:0] MY_C = CW'(IDX);
  localparam logic [IW-1:0] MY_I = IW'(IDX);

  logic [tcpq_pkg::ID_W-1:0] id_r, id_nxt;
  logic                      cls_r, cls_nxt;

  assign id    = id_r;
  assign cls   = cls_r;
  assign match = (MY_C < count) && (id_r == req_id);

  always_comb begin
    id_nxt  = id_r;
    cls_nxt = cls_r;
    priority if (cmd.serve || (cmd.withdraw && (MY_I >= hit_pos))) begin
      id_nxt  = right_id;
      cls_nxt = right_cls;
    end else if (cmd.ins_pref && (MY_C > pcount)) begin
      id_nxt  = left_id;
      cls_nxt = left_cls;
    end else if ((cmd.ins_pref && (MY_C == pcount)) ||
                 (cmd.ins_tail && (MY_C == count))) begin
      id_nxt  = req_id;
      cls_nxt = req_cls;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cls_r <= cls_nxt;
  end

endmodule

// File: rtl/two_class_priority_queue.sv
// two_class_priority_queue: top level, a row of tcpq_cell slots plus counters
// and a registered result stage; depends on tcpq_pkg and tcpq_cell
//
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: op, person_id; tuser: preferred
// out_    | out | out_tvalid/out_tready | tdata: ok, served_id, occupancy;
//         |     |                     | tuser: class_out
//
// one item per cycle: every cell compares its id and shifts in the same cycle,
// the result shows in the output register in the cycle after acceptance
// the result register frees up in the cycle it is taken, so items flow
// back to back while out_tready is high; a stalled result holds the input
// reset clears the counters and the result valid; slot contents are not cleared

module two_class_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] op, [32:2] person_id, rest zero
  input  logic        in_tuser,   // [0] preferred
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] ok, [31:1] served_id, [36:32] occupancy
  output logic        out_tuser   // [0] class_out
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pcount_r, pcount_nxt;

  logic                        out_valid_r;
  logic                        ok_r;
  logic [tcpq_pkg::ID_W-1:0]   served_r;
  logic                        cls_out_r;
  logic [tcpq_pkg::OCC_W-1:0]  occ_r;

  logic                        accept;
  tcpq_pkg::op_t               op;
  logic [tcpq_pkg::ID_W-1:0]   req_id;
  logic                        req_pref;
  tcpq_pkg::cmd_t              cmd;

  logic [tcpq_pkg::ID_W-1:0]   cell_id  [CAPACITY];
  logic                        cell_cls [CAPACITY];
  logic [CAPACITY-1:0]         hit;
  logic [IW-1:0]               hit_pos;
  logic                        hit_cls;
  logic                        found;
  logic                        ins_ok;
  logic                        res_ok;
  logic [tcpq_pkg::ID_W-1:0]   res_served;
  logic                        res_cls;
  logic [31:0]                 count_wide;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign op        = tcpq_pkg::op_t'(in_tdata[1:0]);
  assign req_id    = in_tdata[32:2];
  assign req_pref  = in_tuser;

  // one-hot hit vector to slot number, plus class of the hit slot
  always_comb begin
    hit_pos = '0;
    hit_cls = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        hit_pos = hit_pos | IW'(i);
        hit_cls = hit_cls | cell_cls[i];
      end
    end
  end

  assign found  = (|hit) && (req_id != '0);
  assign ins_ok = (req_id != '0) && !(|hit) && (count_r < CAP_C);

  always_comb begin
    cmd        = '0;
    res_ok     = 1'b0;
    res_served = '0;
    res_cls    = 1'b0;
    count_nxt  = count_r;
    pcount_nxt = pcount_r;
    unique case (op)
      tcpq_pkg::OP_INSERT: begin
        res_ok = ins_ok;
        if (ins_ok) begin
          cmd.ins_pref = req_pref;
          cmd.ins_tail = !req_pref;
          count_nxt    = count_r + 1'b1;
          if (req_pref) pcount_nxt = pcount_r + 1'b1;
        end
      end
      tcpq_pkg::OP_SERVE: begin
        if (count_r != '0) begin
          res_ok     = 1'b1;
          res_served = cell_id[0];
          res_cls    = cell_cls[0];
          cmd.serve  = 1'b1;
          count_nxt  = count_r - 1'b1;
          if (cell_cls[0]) pcount_nxt = pcount_r - 1'b1;
        end
      end
      tcpq_pkg::OP_WITHDRAW: begin
        res_ok = found;
        if (found) begin
          cmd.withdraw = 1'b1;
          count_nxt    = count_r - 1'b1;
          if (hit_cls) pcount_nxt = pcount_r - 1'b1;
        end
      end
      tcpq_pkg::OP_LOOKUP: begin
        res_ok  = found;
        res_cls = found && hit_cls;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (!accept) cmd = '0;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [tcpq_pkg::ID_W-1:0] l_id, r_id;
      logic                      l_cls, r_cls;
      if (g == 0) begin : g_head
        assign l_id  = '0;
        assign l_cls = 1'b0;
      end else begin : g_mid
        assign l_id  = cell_id[g-1];
        assign l_cls = cell_cls[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign r_id  = '0;
        assign r_cls = 1'b0;
      end else begin : g_body
        assign r_id  = cell_id[g+1];
        assign r_cls = cell_cls[g+1];
      end
      tcpq_cell #(
        .IDX (g),
        .CW  (CW),
        .IW  (IW)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .req_id    (req_id),
        .req_cls   (req_pref),
        .count     (count_r),
        .pcount    (pcount_r),
        .hit_pos   (hit_pos),
        .left_id   (l_id),
        .left_cls  (l_cls),
        .right_id  (r_id),
        .right_cls (r_cls),
        .id        (cell_id[g]),
        .cls       (cell_cls[g]),
        .match     (hit[g])
      );
    end
  endgenerate

  // occupancy field keeps the low bits of the count
  assign count_wide = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        pcount_r    <= pcount_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r      <= res_ok;
      served_r  <= res_served;
      cls_out_r <= res_cls;
      occ_r     <= count_wide[tcpq_pkg::OCC_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, occ_r, served_r, ok_r};
  assign out_tuser  = cls_out_r;

endmodule

// File: tb/testbench.sv
// testbench for two_class_priority_queue: drives request items, predicts each
// result in a scoreboard class and checks the result stream; needs tcpq_pkg
`timescale 1ns / 100ps

typedef struct packed {
  bit                          ok;
  bit [tcpq_pkg::ID_W-1:0]     served_id;
  bit                          class_out;
  bit [tcpq_pkg::OCC_W-1:0]    occupancy;
} reply_t;

// keeps its own copy of the ordered store and the replies still to come
class queue_order_tracker;
  localparam int SLOTS = 16;

  bit [tcpq_pkg::ID_W-1:0] held_ids[$];
  bit            held_pref[$];
  int unsigned   pref_total;
  reply_t        awaited[$];
  int            errors;

  function int slot_of(bit [tcpq_pkg::ID_W-1:0] id);
    for (int i = 0; i < held_ids.size(); i++)
      if (held_ids[i] == id) return i;
    return -1;
  endfunction

  function int held_count();
    return held_ids.size();
  endfunction

  function bit [tcpq_pkg::ID_W-1:0] any_held_id();
    return held_ids[$urandom_range(0, held_ids.size() - 1)];
  endfunction

  function void note_request(tcpq_pkg::op_t op, bit [tcpq_pkg::ID_W-1:0] id, bit pref);
    reply_t r;
    int     pos;
    r   = '0;
    pos = slot_of(id);
    case (op)
      tcpq_pkg::OP_INSERT: begin
        if (id != 0 && pos < 0 && held_ids.size() < SLOTS) begin
          // preferred entries queue up behind the last preferred one
          if (pref) begin
            held_ids.insert(pref_total, id);
            held_pref.insert(pref_total, 1'b1);
            pref_total++;
          end else begin
            held_ids.push_back(id);
            held_pref.push_back(1'b0);
          end
          r.ok = 1'b1;
        end
      end
      tcpq_pkg::OP_SERVE: begin
        if (held_ids.size() > 0) begin
          r.ok        = 1'b1;
          r.served_id = held_ids.pop_front();
          r.class_out = held_pref.pop_front();
          if (r.class_out) pref_total--;
        end
      end
      tcpq_pkg::OP_WITHDRAW: begin
        if (id != 0 && pos >= 0) begin
          if (held_pref[pos]) pref_total--;
          held_ids.delete(pos);
          held_pref.delete(pos);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (id != 0 && pos >= 0) begin
          r.ok        = 1'b1;
          r.class_out = held_pref[pos];
        end
      end
    endcase
    r.occupancy = tcpq_pkg::OCC_W'(held_ids.size());
    awaited.push_back(r);
  endfunction

  function void check_reply(reply_t got);
    reply_t want;
    if (awaited.size() == 0) begin
      $display("%0t: result with none expected: %h", $time, got);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.ok != want.ok) begin
      $display("%0t: ok expected %0d got %0d", $time, want.ok, got.ok);
      errors++;
    end
    if (got.served_id != want.served_id) begin
      $display("%0t: served_id expected %h got %h", $time, want.served_id, got.served_id);
      errors++;
    end
    if (got.class_out != want.class_out) begin
      $display("%0t: class_out expected %0d got %0d", $time, want.class_out,
               got.class_out);
      errors++;
    end
    if (got.occupancy != want.occupancy) begin
      $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
               got.occupancy);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_TAIL    = 300;
  localparam bit [tcpq_pkg::ID_W-1:0] ID_MAX = {tcpq_pkg::ID_W{1'b1}};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;

  queue_order_tracker tracker;
  bit            idling_on;
  int            stall_left;
  bit [tcpq_pkg::ID_W-1:0] id_pool[40];

  two_class_priority_queue #(.CAPACITY(16)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // result side stalls in bursts
  always @(negedge clk) begin
    if (idling_on && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 14);
    if (idling_on && stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok        = out_tdata[0];
      got.served_id = out_tdata[31:1];
      got.occupancy = out_tdata[36:32];
      got.class_out = out_tuser;
      tracker.check_reply(got);
    end
  end

  // called on a falling edge, returns on the falling edge after acceptance
  task automatic send_request(tcpq_pkg::op_t op, bit [tcpq_pkg::ID_W-1:0] id, bit pref);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'b0, id, op};
    in_tuser  = pref;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(op, id, pref);
    @(negedge clk);
  endtask

  function automatic bit [tcpq_pkg::ID_W-1:0] choose_id();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50 && tracker.held_count() > 0) return tracker.any_held_id();
    if (pick < 85) return id_pool[$urandom_range(0, 39)];
    if (pick < 95) return tcpq_pkg::ID_W'($urandom()) & ID_MAX;
    return pick[0] ? ID_MAX : '0;
  endfunction

  function automatic tcpq_pkg::op_t choose_op(int mode);
    int w;
    w = $urandom_range(0, 99);
    case (mode)
      0: return w < 70 ? tcpq_pkg::OP_INSERT :
                w < 80 ? tcpq_pkg::OP_SERVE :
                w < 90 ? tcpq_pkg::OP_WITHDRAW : tcpq_pkg::OP_LOOKUP;
      1: return w < 15 ? tcpq_pkg::OP_INSERT :
                w < 55 ? tcpq_pkg::OP_SERVE :
                w < 85 ? tcpq_pkg::OP_WITHDRAW : tcpq_pkg::OP_LOOKUP;
      default: return tcpq_pkg::op_t'(w[1:0]);
    endcase
  endfunction

  initial begin
    int mode;
    tracker    = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    idling_on  = 1'b1;
    stall_left = 0;
    foreach (id_pool[i]) id_pool[i] = (tcpq_pkg::ID_W'($urandom()) & ID_MAX) | 31'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, zero id, extremes, duplicates, class ordering
    send_request(tcpq_pkg::OP_SERVE,    '0,           1'b0);
    send_request(tcpq_pkg::OP_LOOKUP,   '0,           1'b1);
    send_request(tcpq_pkg::OP_WITHDRAW, '0,           1'b0);
    send_request(tcpq_pkg::OP_INSERT,   '0,           1'b1);
    send_request(tcpq_pkg::OP_INSERT,   ID_MAX,       1'b0);
    send_request(tcpq_pkg::OP_INSERT,   31'd1,        1'b1);
    send_request(tcpq_pkg::OP_INSERT,   31'd1,        1'b0);
    send_request(tcpq_pkg::OP_INSERT,   ID_MAX,       1'b1);
    send_request(tcpq_pkg::OP_LOOKUP,   ID_MAX,       1'b1);
    send_request(tcpq_pkg::OP_LOOKUP,   31'd1,        1'b0);
    send_request(tcpq_pkg::OP_LOOKUP,   31'd5,        1'b0);
    send_request(tcpq_pkg::OP_INSERT,   31'h2AAAAAAA, 1'b1);
    send_request(tcpq_pkg::OP_INSERT,   31'h55555555, 1'b0);
    send_request(tcpq_pkg::OP_WITHDRAW, 31'd7,        1'b1);
    send_request(tcpq_pkg::OP_WITHDRAW, ID_MAX,       1'b0);
    send_request(tcpq_pkg::OP_SERVE,    31'h1234,     1'b1);
    send_request(tcpq_pkg::OP_SERVE,    '0,           1'b0);
    send_request(tcpq_pkg::OP_SERVE,    '0,           1'b0);
    send_request(tcpq_pkg::OP_SERVE,    '0,           1'b1);
    send_request(tcpq_pkg::OP_LOOKUP,   31'd1,        1'b0);

    // random: phases that fill, drain or mix, so the store swings empty to full
    mode = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      if (n >= RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
      send_request(choose_op(mode), choose_id(), 1'($urandom_range(0, 1)));
    end
    in_tvalid = 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("PASS two_class_priority_queue");
    end else begin
      $display("FAIL two_class_priority_queue");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL two_class_priority_queue");
    $finish;
  end
endmodule
